// ----- rtl/core/lmss_pkg.sv -----
// Shared types and constants for the lamp mode and SOS sequencer.
package lmss_pkg;

  // Width of the blink counter and of the next-event time.
  localparam int unsigned CntW = 16;
  localparam int unsigned StepW = 5;
  localparam int unsigned UnitW = 8;
  // Holds 7 * unit_ticks.
  localparam int unsigned GapW = UnitW + 3;
  // Signed difference of two counter values, no wrap.
  localparam int unsigned DiffW = CntW + 2;

  localparam logic [UnitW-1:0] UnitReset = UnitW'(15);

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_BLINK = 2'd2;
  localparam logic [1:0] MODE_SOS   = 2'd3;

  localparam logic [0:0] OP_TICK  = 1'b0;
  localparam logic [0:0] OP_PRESS = 1'b1;

  // Step after which the long pause follows.
  localparam logic [StepW-1:0] StepLast = StepW'(18);

  typedef struct packed {
    logic             lamp;
    logic [StepW-1:0] step;
    logic [CntW-1:0]  next_time;
  } lmss_sos_t;

  typedef struct packed {
    logic       lamp_active;
    logic [1:0] mode;
    logic       lamp;
  } lmss_res_t;

endpackage

// ----- rtl/core/lmss_sos.sv -----
// Combinational SOS tick: resync, event timing and step advance.
module lmss_sos (
  input  logic [lmss_pkg::CntW-1:0]  cnt_i,
  input  logic [lmss_pkg::UnitW-1:0] unit_i,
  input  lmss_pkg::lmss_sos_t        cur_i,
  output lmss_pkg::lmss_sos_t        nxt_o
);
  import lmss_pkg::*;

  logic [GapW-1:0]         gap1, gap3, gap7, gap;
  logic signed [DiffW-1:0] diff, lim;
  logic                    resync, hit;
  logic [CntW-1:0]         evt_time;
  logic [StepW-1:0]        step_base;

  assign gap1 = GapW'(unit_i);
  assign gap3 = GapW'(unit_i) + GapW'({unit_i, 1'b0});
  assign gap7 = GapW'({unit_i, 3'b000}) - GapW'(unit_i);

  assign diff   = signed'({2'b00, cnt_i}) - signed'({2'b00, cur_i.next_time});
  assign lim    = signed'(DiffW'(gap7));
  assign resync = diff > lim;
  assign hit    = cnt_i == cur_i.next_time;

  always_comb begin
    step_base = cur_i.step;
    if (cur_i.step >= StepLast) begin
      gap       = gap7;
      step_base = '0;
    end else if (cur_i.step inside {5'd7, 5'd9, 5'd11}) begin
      gap = gap3;
    end else begin
      gap = gap1;
    end
  end

  assign evt_time = cnt_i + CntW'(gap);

  always_comb begin
    nxt_o = cur_i;
    if (resync) begin
      nxt_o.step      = '0;
      nxt_o.next_time = cnt_i + CntW'(1);
    end else if (hit) begin
      // first step of a round always starts dark
      nxt_o.lamp      = (cur_i.step == '0) ? 1'b0 : ~cur_i.lamp;
      nxt_o.next_time = evt_time;
      nxt_o.step      = step_base + StepW'(1);
    end
  end

endmodule

// ----- rtl/core/lmss_ctrl.sv -----
// Lamp and mode state with per-beat next-state logic.
module lmss_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       op_i,
  input  logic [lmss_pkg::CntW-1:0]  cnt_i,
  input  logic [lmss_pkg::UnitW-1:0] unit_i,
  output lmss_pkg::lmss_res_t        res_o
);
  import lmss_pkg::*;

  logic       lamp_q, lamp_d;
  logic [1:0] mode_q, mode_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0]  next_q, next_d;
  lmss_sos_t  sos_cur, sos_nxt;

  assign sos_cur = '{lamp: lamp_q, step: step_q, next_time: next_q};

  lmss_sos u_sos (
    .cnt_i  (cnt_i),
    .unit_i (unit_i),
    .cur_i  (sos_cur),
    .nxt_o  (sos_nxt)
  );

  always_comb begin
    lamp_d = lamp_q;
    mode_d = mode_q;
    step_d = step_q;
    next_d = next_q;
    if (op_i == OP_PRESS) begin
      if (mode_q == MODE_OFF) begin
        lamp_d = 1'b1;
      end else if (mode_q == MODE_SOS) begin
        lamp_d = 1'b0;
      end
      mode_d = mode_q + 2'd1;
    end else begin
      case (mode_q)
        MODE_BLINK: begin
          if (cnt_i[3:0] == 4'd0) begin
            lamp_d = ~lamp_q;
          end
        end
        MODE_SOS: begin
          lamp_d = sos_nxt.lamp;
          step_d = sos_nxt.step;
          next_d = sos_nxt.next_time;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lamp_q <= 1'b0;
      mode_q <= MODE_OFF;
      step_q <= '0;
      next_q <= '0;
    end else if (en_i) begin
      lamp_q <= lamp_d;
      mode_q <= mode_d;
      step_q <= step_d;
      next_q <= next_d;
    end
  end

  assign res_o = '{lamp_active: (mode_d != MODE_OFF), mode: mode_d, lamp: lamp_d};

endmodule

// ----- rtl/core/lamp_mode_and_sos_sequencer_unit.sv -----
// Lamp mode and SOS sequencer, top level with stream ports.
//
// Each input beat is a tick (tuser = 0, tdata = blink counter) or a mode
// button press (tuser = 1) and yields exactly one output beat with the lamp
// level, the mode and the lamp-active flag after that item. A beat is held in
// the input register, then the state update and result are computed in a
// single pass into the output register; one beat is taken every cycle while
// the output side keeps up. The SOS unit length (cfg_wdata_i, counter ticks,
// reset 15) is written with cfg_we_i and should only change while no beat is
// in flight.
module lamp_mode_and_sos_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] blink_count
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] lamp, [2:1] mode, [3] lamp_active
);
  import lmss_pkg::*;

  logic [UnitW-1:0] unit_q;
  logic             in_vld_q;
  logic             op_q;
  logic [15:0]      cnt_q;
  logic             out_vld_q;
  lmss_res_t        res_q, res_d;
  logic             adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= UnitReset;
    end else if (cfg_we_i) begin
      unit_q <= cfg_wdata_i;
    end
  end

  // input stage moves on when the result register is free or draining
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q  <= s_axis_tuser;
      cnt_q <= s_axis_tdata;
    end
  end

  lmss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .op_i   (op_q),
    .cnt_i  (cnt_q[CntW-1:0]),
    .unit_i (unit_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, res_q};

endmodule
